### design/lyndon_word_enumerator_macros.svh
// Assertion macros for the Lyndon word enumerator.
// Needs clk_i and rst_ni in the scope of the including module.
`ifndef LYNDON_WORD_ENUMERATOR_MACROS_SVH
`define LYNDON_WORD_ENUMERATOR_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LWE_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LWE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/lwe_pkg.sv
// Package for the Lyndon word enumerator: default sizes, register indexes,
// sequencer step, operation and branch codes, and the control program.
// No dependencies.
package lwe_pkg;

  localparam int DEF_MAX_DEPTH   = 8;
  localparam int DEF_LETTER_BITS = 4;

  localparam int CFG_IDX_W = 1;
  localparam int CFG_W     = 5;
  localparam int CC_W      = 5;
  localparam int ML_W      = 4;
  localparam int LETTERS_W = 32;
  localparam int WLEN_W    = 4;
  localparam int INDEX_W   = 33;

  localparam logic [CC_W-1:0] CC_RESET = 5'd2;
  localparam logic [ML_W-1:0] ML_RESET = 4'd4;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CHANNEL_COUNT = 1'b0,
    CFG_MAX_LENGTH    = 1'b1
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_START,
    ST_CHECK,
    ST_RD_TAIL,
    ST_INC,
    ST_RD_FIRST,
    ST_HORNER,
    ST_EXT_CHK,
    ST_EXT,
    ST_STRIP_RD,
    ST_STRIP,
    ST_FINISH,
    ST_EMPTY
  } step_e;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_ACCEPT,
    OP_START,
    OP_RD_TAIL,
    OP_INC,
    OP_RD_FIRST,
    OP_HORNER,
    OP_EXT_RD,
    OP_EXT,
    OP_STRIP_RD,
    OP_STRIP,
    OP_FINISH,
    OP_EMPTY
  } op_e;

  typedef enum logic [1:0] {
    BR_NEXT,
    BR_IF,
    BR_WAIT,
    BR_JUMP
  } br_e;

  typedef enum logic [2:0] {
    CD_REQ,
    CD_RESTART,
    CD_DRY,
    CD_MORE,
    CD_FULL,
    CD_EXT_MORE,
    CD_STRIP_MORE,
    CD_OUT_FREE
  } cond_e;

  typedef struct packed {
    op_e   op;
    br_e   br;
    cond_e cond;
    step_e target;
  } uword_t;

  // BR_IF goes to the target when the condition holds and falls through
  // otherwise. BR_WAIT stays on the step until the condition holds.
  function automatic uword_t ucode(step_e s);
    uword_t w;
    case (s)
      ST_IDLE:     w = '{OP_ACCEPT,   BR_WAIT, CD_REQ,        ST_START};
      ST_START:    w = '{OP_START,    BR_IF,   CD_RESTART,    ST_RD_FIRST};
      ST_CHECK:    w = '{OP_NONE,     BR_IF,   CD_DRY,        ST_EMPTY};
      ST_RD_TAIL:  w = '{OP_RD_TAIL,  BR_NEXT, CD_REQ,        ST_IDLE};
      ST_INC:      w = '{OP_INC,      BR_NEXT, CD_REQ,        ST_IDLE};
      ST_RD_FIRST: w = '{OP_RD_FIRST, BR_NEXT, CD_REQ,        ST_IDLE};
      ST_HORNER:   w = '{OP_HORNER,   BR_IF,   CD_MORE,       ST_HORNER};
      ST_EXT_CHK:  w = '{OP_EXT_RD,   BR_IF,   CD_FULL,       ST_STRIP_RD};
      ST_EXT:      w = '{OP_EXT,      BR_IF,   CD_EXT_MORE,   ST_EXT};
      ST_STRIP_RD: w = '{OP_STRIP_RD, BR_NEXT, CD_REQ,        ST_IDLE};
      ST_STRIP:    w = '{OP_STRIP,    BR_IF,   CD_STRIP_MORE, ST_STRIP};
      ST_FINISH:   w = '{OP_FINISH,   BR_WAIT, CD_OUT_FREE,   ST_IDLE};
      ST_EMPTY:    w = '{OP_EMPTY,    BR_WAIT, CD_OUT_FREE,   ST_IDLE};
      default:     w = '{OP_NONE,     BR_JUMP, CD_REQ,        ST_IDLE};
    endcase
    return w;
  endfunction

endpackage

### design/lyndon_word_enumerator.sv
// Lyndon word enumerator on a microcoded sequencer; depends on lwe_pkg and the macros header.
// A request is taken in the idle step and its result is offered from the finish or empty
// step, which waits for the output to be free; a restart skips the check and increment
// steps. The next request can be taken in the cycle after the result is offered.
// Reset is asynchronous: channel_count 2, max_length 4, store empty, not started.
`include "lyndon_word_enumerator_macros.svh"

module lyndon_word_enumerator import lwe_pkg::*; #(
  parameter int MAX_DEPTH   = DEF_MAX_DEPTH,
  parameter int LETTER_BITS = DEF_LETTER_BITS
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic                 restart_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic                 valid_res_o,
  output logic [LETTERS_W-1:0] letters_o,
  output logic [WLEN_W-1:0]    word_length_o,
  output logic [INDEX_W-1:0]   tensor_index_o,
  output logic                 last_word_o
);

  localparam int AW    = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
  localparam int DEPTH = 1 << AW;
  localparam int LW    = $clog2(MAX_DEPTH + 1);
  localparam int LB    = LETTER_BITS;
  localparam int PW    = MAX_DEPTH * LETTER_BITS;
  localparam logic [CC_W:0] C_CLAMP = (LETTER_BITS >= CC_W) ? (CC_W+1)'(31)
                                                            : (CC_W+1)'(1 << LETTER_BITS);
  localparam logic [ML_W:0] M_CLAMP = (ML_W+1)'(MAX_DEPTH);

  logic [CC_W-1:0]    cc_q;
  logic [ML_W-1:0]    ml_q;
  logic [CC_W-1:0]    c_eff;
  logic [CC_W-1:0]    c_m1;
  logic [ML_W:0]      m_wide;
  logic [LW-1:0]      m_eff;

  step_e              upc_q, upc_d;
  uword_t             uw;
  logic               cond;
  logic               out_free;
  logic               strip_hit;

  logic               rst_req_q;
  logic               started_q;
  logic               exhausted_q;
  logic [LW-1:0]      cur_q;
  logic [LW-1:0]      i_q;
  logic [LW-1:0]      len_q;
  logic [AW-1:0]      pos_q;
  logic [INDEX_W-1:0] acc_q;
  logic [INDEX_W-1:0] mul;
  logic [PW-1:0]      packed_q;
  logic [PW+LETTERS_W-1:0] packed_ext;

  logic [LB-1:0]      mem_q [DEPTH];
  logic [DEPTH-1:0]   vld_q;
  logic [LB-1:0]      rd_q;
  logic               we;
  logic [AW-1:0]      waddr;
  logic [LB-1:0]      wdata;
  logic [AW-1:0]      raddr;

  logic               out_valid_q;
  logic               res_valid_q;
  logic [LETTERS_W-1:0] res_letters_q;
  logic [LW-1:0]      res_len_q;
  logic [LW+WLEN_W-1:0] res_len_ext;
  logic [INDEX_W-1:0] res_index_q;
  logic               res_last_q;

  // Clamped configuration values.
  always_comb begin
    if (cc_q == '0) begin
      c_eff = CC_W'(1);
    end else if ({1'b0, cc_q} > C_CLAMP) begin
      c_eff = C_CLAMP[CC_W-1:0];
    end else begin
      c_eff = cc_q;
    end
    if (ml_q == '0) begin
      m_wide = (ML_W+1)'(1);
    end else if ({1'b0, ml_q} > M_CLAMP) begin
      m_wide = M_CLAMP;
    end else begin
      m_wide = {1'b0, ml_q};
    end
    m_eff = LW'(m_wide);
    c_m1  = c_eff - CC_W'(1);
  end

  assign uw        = ucode(upc_q);
  assign out_free  = !out_valid_q || out_ready_i;
  assign strip_hit = (9'(rd_q) >= 9'(c_m1));
  assign mul       = acc_q * INDEX_W'(c_eff);
  assign in_ready_o = (upc_q == ST_IDLE);

  // Sequencer: condition select and next step.
  always_comb begin
    case (uw.cond)
      CD_REQ:        cond = in_valid_i;
      CD_RESTART:    cond = rst_req_q;
      CD_DRY:        cond = exhausted_q || (cur_q == '0);
      CD_MORE:       cond = LW'(i_q + LW'(1)) < cur_q;
      CD_FULL:       cond = cur_q >= m_eff;
      CD_EXT_MORE:   cond = LW'(cur_q + LW'(1)) < m_eff;
      CD_STRIP_MORE: cond = strip_hit && (cur_q > LW'(1));
      CD_OUT_FREE:   cond = out_free;
      default:       cond = 1'b0;
    endcase
    case (uw.br)
      BR_NEXT: upc_d = step_e'(4'(upc_q + 4'd1));
      BR_IF:   upc_d = cond ? uw.target : step_e'(4'(upc_q + 4'd1));
      BR_WAIT: upc_d = cond ? uw.target : upc_q;
      BR_JUMP: upc_d = uw.target;
      default: upc_d = ST_IDLE;
    endcase
  end

  // Letter store ports.
  always_comb begin
    we    = 1'b0;
    waddr = '0;
    wdata = '0;
    raddr = '0;
    case (uw.op)
      OP_RD_TAIL: begin
        raddr = AW'(cur_q - LW'(1));
      end
      OP_INC: begin
        we    = 1'b1;
        waddr = AW'(cur_q - LW'(1));
        wdata = LB'(rd_q + LB'(1));
      end
      OP_HORNER: begin
        raddr = AW'(i_q + LW'(1));
      end
      OP_EXT: begin
        we    = 1'b1;
        waddr = AW'(cur_q);
        wdata = rd_q;
        raddr = AW'(pos_q + AW'(1));
      end
      OP_STRIP_RD: begin
        raddr = AW'(cur_q - LW'(1));
      end
      OP_STRIP: begin
        we    = strip_hit;
        waddr = AW'(cur_q - LW'(1));
        raddr = AW'(cur_q - LW'(2));
      end
      default: begin
        raddr = '0;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q       <= ST_IDLE;
      cc_q        <= CC_RESET;
      ml_q        <= ML_RESET;
      rst_req_q   <= 1'b0;
      started_q   <= 1'b0;
      exhausted_q <= 1'b0;
      cur_q       <= '0;
      vld_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      upc_q <= upc_d;
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_CHANNEL_COUNT: cc_q <= cfg_data_i;
          CFG_MAX_LENGTH:    ml_q <= cfg_data_i[ML_W-1:0];
          default:           cc_q <= cc_q;
        endcase
      end
      if (we) begin
        vld_q[waddr] <= 1'b1;
      end
      if (((uw.op == OP_FINISH) || (uw.op == OP_EMPTY)) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (uw.op)
        OP_ACCEPT: begin
          if (in_valid_i) begin
            rst_req_q <= restart_i || !started_q;
          end
        end
        OP_START: begin
          if (rst_req_q) begin
            vld_q       <= '0;
            cur_q       <= LW'(1);
            started_q   <= 1'b1;
            exhausted_q <= 1'b0;
          end
        end
        OP_EXT: begin
          cur_q <= LW'(cur_q + LW'(1));
        end
        OP_STRIP: begin
          if (strip_hit) begin
            cur_q <= LW'(cur_q - LW'(1));
          end
        end
        OP_FINISH: begin
          if (out_free) begin
            exhausted_q <= (cur_q == '0);
          end
        end
        default: begin
          rst_req_q <= rst_req_q;
        end
      endcase
    end
  end

  // Letter store; a read of the entry written in the same cycle sees the new letter.
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    if (we && (waddr == raddr)) begin
      rd_q <= wdata;
    end else if (vld_q[raddr]) begin
      rd_q <= mem_q[raddr];
    end else begin
      rd_q <= '0;
    end
  end

  // Datapath and result registers.
  always_ff @(posedge clk_i) begin
    case (uw.op)
      OP_ACCEPT: begin
        i_q      <= '0;
        acc_q    <= '0;
        packed_q <= '0;
      end
      OP_HORNER: begin
        acc_q                  <= mul + INDEX_W'(rd_q) + INDEX_W'(1);
        packed_q[i_q*LB +: LB] <= rd_q;
        i_q                    <= LW'(i_q + LW'(1));
        len_q                  <= cur_q;
      end
      OP_EXT_RD: begin
        pos_q <= '0;
      end
      OP_EXT: begin
        pos_q <= AW'(pos_q + AW'(1));
      end
      OP_FINISH: begin
        if (out_free) begin
          res_valid_q   <= 1'b1;
          res_letters_q <= packed_ext[LETTERS_W-1:0];
          res_len_q     <= len_q;
          res_index_q   <= acc_q - INDEX_W'(1);
          res_last_q    <= (cur_q == '0);
        end
      end
      OP_EMPTY: begin
        if (out_free) begin
          res_valid_q   <= 1'b0;
          res_letters_q <= '0;
          res_len_q     <= '0;
          res_index_q   <= '0;
          res_last_q    <= 1'b0;
        end
      end
      default: begin
        pos_q <= pos_q;
      end
    endcase
  end

  assign packed_ext     = {{LETTERS_W{1'b0}}, packed_q};
  assign res_len_ext    = {{WLEN_W{1'b0}}, res_len_q};
  assign out_valid_o    = out_valid_q;
  assign valid_res_o    = res_valid_q;
  assign letters_o      = res_letters_q;
  assign word_length_o  = res_len_ext[WLEN_W-1:0];
  assign tensor_index_o = res_index_q;
  assign last_word_o    = res_last_q;

  `LWE_ASSERT_NEXT(a_accept_starts, in_valid_i && in_ready_o, upc_q == ST_START, "request lost")
  `LWE_ASSERT_SAME(a_exhausted_empty, exhausted_q, cur_q == '0, "exhausted with a stored word")
  `LWE_ASSERT_SAME(a_empty, out_valid_q && !res_valid_q, !res_last_q, "empty result last")

endmodule

### tb/sv/tb_lyndon_word_enumerator.sv
`timescale 1ns / 100ps
// Self-checking testbench for lyndon_word_enumerator: directed walks and random requests
// under changing alphabet and length settings, checked against a Duval-step predictor.
// Depends on lwe_pkg and the enumerator RTL.
module tb_lyndon_word_enumerator;
  import lwe_pkg::*;

  localparam int DEPTH       = DEF_MAX_DEPTH;
  localparam int LBITS       = DEF_LETTER_BITS;
  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASES      = 10;
  localparam int PHASE_ITEMS = 50;

  typedef struct packed {
    logic                 valid;
    logic [LETTERS_W-1:0] letters;
    logic [WLEN_W-1:0]    len;
    logic [INDEX_W-1:0]   idx;
    logic                 last;
  } word_res_t;

  class lyndon_scoreboard;
    logic [CC_W-1:0]  cc_val;
    logic [ML_W-1:0]  ml_val;
    logic [LBITS-1:0] store [DEPTH];
    int unsigned      cur_len;
    bit               started;
    bit               exhausted;
    word_res_t        pending_words [$];
    int               mismatches;

    function new();
      cc_val     = CC_RESET;
      ml_val     = ML_RESET;
      cur_len    = 0;
      started    = 0;
      exhausted  = 0;
      mismatches = 0;
      foreach (store[i]) store[i] = '0;
    endfunction

    function void write_reg(cfg_idx_e idx, logic [CFG_W-1:0] d);
      if (idx == CFG_CHANNEL_COUNT) cc_val = d[CC_W-1:0];
      else ml_val = d[ML_W-1:0];
    endfunction

    function word_res_t duval_step(bit restart);
      word_res_t       r;
      int unsigned     c, m, len, pos, i;
      longint unsigned value, offset, power;
      r = '0;
      value = 0;
      offset = 0;
      power = 1;
      c = cc_val;
      if (c < 1) c = 1;
      if (c > (1 << LBITS)) c = 1 << LBITS;
      m = ml_val;
      if (m < 1) m = 1;
      if (m > DEPTH) m = DEPTH;
      if (restart || !started) begin
        foreach (store[k]) store[k] = '0;
        cur_len = 1;
        started = 1;
        exhausted = 0;
      end else if (exhausted || cur_len == 0 || cur_len > DEPTH) begin
        return r;
      end else begin
        store[cur_len-1] = store[cur_len-1] + 1'b1;
      end
      len = cur_len;
      for (i = 0; i < len; i++) begin
        r.letters = r.letters | (LETTERS_W'(store[i]) << (LBITS * i));
        value = value * c + store[i];
      end
      for (i = 1; i < len; i++) begin
        power = power * c;
        offset = offset + power;
      end
      pos = 0;
      while (cur_len < m) begin
        store[cur_len] = store[pos];
        cur_len++;
        pos++;
      end
      while (cur_len > 0 && store[cur_len-1] >= c - 1) begin
        store[cur_len-1] = '0;
        cur_len--;
      end
      if (cur_len == 0) exhausted = 1;
      r.valid = 1'b1;
      r.len   = WLEN_W'(len);
      r.idx   = INDEX_W'(offset + value);
      r.last  = exhausted;
      return r;
    endfunction

    function void note_request(bit restart);
      pending_words = {pending_words, duval_step(restart)};
    endfunction

    function void cmp_field(string name, logic [INDEX_W-1:0] e, logic [INDEX_W-1:0] a);
      if (a !== e) begin
        mismatches++;
        $display("%0t: %s mismatch, expected %h, actual %h", $time, name, e, a);
      end
    endfunction

    function void check_word(word_res_t got);
      word_res_t exp;
      if (pending_words.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result, expected none, actual %h", $time, got);
        return;
      end
      exp = pending_words.pop_front();
      cmp_field("valid_res", INDEX_W'(exp.valid), INDEX_W'(got.valid));
      cmp_field("letters", INDEX_W'(exp.letters), INDEX_W'(got.letters));
      cmp_field("word_length", INDEX_W'(exp.len), INDEX_W'(got.len));
      cmp_field("tensor_index", exp.idx, got.idx);
      cmp_field("last_word", INDEX_W'(exp.last), INDEX_W'(got.last));
    endfunction

    function int pending();
      return pending_words.size();
    endfunction
  endclass

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_W-1:0]     cfg_data_i;
  logic                 in_valid_i;
  logic                 in_ready_o;
  logic                 restart_i;
  logic                 out_valid_o;
  logic                 out_ready_i;
  logic                 valid_res_o;
  logic [LETTERS_W-1:0] letters_o;
  logic [WLEN_W-1:0]    word_length_o;
  logic [INDEX_W-1:0]   tensor_index_o;
  logic                 last_word_o;

  lyndon_word_enumerator u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .restart_i      (restart_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .valid_res_o    (valid_res_o),
    .letters_o      (letters_o),
    .word_length_o  (word_length_o),
    .tensor_index_o (tensor_index_o),
    .last_word_o    (last_word_o)
  );

  lyndon_scoreboard sb;
  int               send_pct;
  int               stall_pct;
  int               cycles;
  word_res_t        seen_word;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      seen_word = {valid_res_o, letters_o, word_length_o, tensor_index_o, last_word_o};
      sb.check_word(seen_word);
    end
  end

  task automatic set_idling(int mode);
    case (mode)
      1: begin
        send_pct = 52;
        stall_pct = 0;
      end
      2: begin
        send_pct = 0;
        stall_pct = 52;
      end
      3: begin
        send_pct = 19;
        stall_pct = 19;
      end
      default: begin
        send_pct = 0;
        stall_pct = 0;
      end
    endcase
  endtask

  function automatic int p_last_mode();
    return 2;
  endfunction

  task automatic write_reg(cfg_idx_e idx, logic [CFG_W-1:0] d);
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_data_i = d;
    @(posedge clk_i);
    sb.write_reg(idx, d);
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    cfg_data_i = CFG_W'($urandom_range(31));
  endtask

  task automatic send_request(bit restart);
    @(negedge clk_i);
    while ($urandom_range(99) < send_pct) begin
      in_valid_i = 1'b0;
      restart_i = 1'($urandom_range(1));
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    restart_i = restart;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_request(restart);
  endtask

  task automatic stop_sending();
    @(negedge clk_i);
    in_valid_i = 1'b0;
  endtask

  task automatic wait_drain();
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  task automatic configure(int cc, int ml);
    stop_sending();
    wait_drain();
    write_reg(CFG_CHANNEL_COUNT, CFG_W'(cc));
    write_reg(CFG_MAX_LENGTH, {1'($urandom_range(1)), ML_W'(ml)});
  endtask

  initial begin
    int cc_set [PHASES];
    int ml_set [PHASES];
    sb = new();
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = CFG_CHANNEL_COUNT;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    restart_i = 1'b0;
    set_idling(0);
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // A request before any word acts as restart; walk the default setting past its end.
    repeat (10) send_request(1'b0);
    send_request(1'b1);
    // Registers changed mid-run: the stored word is already longer than max_length.
    configure(3, 2);
    repeat (2) send_request(1'b0);
    // Largest alphabet, length one: every letter up to the top value.
    configure(31, 1);
    send_request(1'b1);
    repeat (15) send_request(1'b0);

    cc_set = '{1, 16, 3, 0, 31, 2, $urandom_range(31), 5, 17, $urandom_range(31)};
    ml_set = '{8, 1, 15, 0, 8, 4, $urandom_range(15), 3, $urandom_range(15), 2};
    for (int p = 0; p < PHASES; p++) begin
      configure(cc_set[p], ml_set[p]);
      set_idling(p % 4);
      if ($urandom_range(1)) send_request(1'b1);
      repeat (PHASE_ITEMS) send_request($urandom_range(19) == 0);
    end
    set_idling(p_last_mode());

    stop_sending();
    wait_drain();
    repeat (40) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
